// File: sv/assert_macros.svh
// Assertion macros shared by the RTL of the vector rotation block.
// Depends on nothing; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif

`endif

// File: sv/tvr_pkg.sv
// Package of the topocentric vector rotation: widths, types, command and
// register codes, and the rounded trig product. Depends on nothing.
`default_nettype none

package tvr_pkg;

    localparam int COMPONENT_WIDTH    = 48;
    localparam int TRIG_FRACTION_BITS = 30;
    localparam int TRIG_W             = 32;
    localparam int NUM_COMP           = 3;
    localparam int PIPE_DEPTH         = 6;
    localparam int CFG_IDX_W          = 8;

    // Matrix entries: trig values and rounded trig products, plus negation.
    localparam int ENT_W  = 2 * TRIG_W - TRIG_FRACTION_BITS;
    // Each component is split in two halves for the multipliers.
    localparam int LO_W   = COMPONENT_WIDTH / 2;
    localparam int HI_W   = COMPONENT_WIDTH - LO_W;
    localparam int PL_W   = LO_W + 1 + ENT_W;
    localparam int PH_W   = HI_W + ENT_W;
    localparam int SL_W   = PL_W + 2;
    localparam int SH_W   = PH_W + 2;
    localparam int BIAS_W = ENT_W + TRIG_FRACTION_BITS;
    localparam int SUM_W  = COMPONENT_WIDTH + ENT_W + 2;
    localparam int RES_W  = SUM_W - TRIG_FRACTION_BITS;
    localparam int DATA_W = ((NUM_COMP * COMPONENT_WIDTH + 7) / 8) * 8;

    typedef logic signed [TRIG_W-1:0]          trig_t;
    typedef logic signed [2*TRIG_W-1:0]        prod_t;
    typedef logic signed [ENT_W-1:0]           ent_t;
    typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;
    typedef logic signed [PL_W-1:0]            pl_t;
    typedef logic signed [PH_W-1:0]            ph_t;
    typedef logic signed [SL_W-1:0]            sl_t;
    typedef logic signed [SH_W-1:0]            sh_t;
    typedef logic signed [BIAS_W-1:0]          bias_t;
    typedef logic signed [SUM_W-1:0]           sum_t;
    typedef logic signed [RES_W-1:0]           res_t;

    typedef enum logic [1:0] {
        CMD_TO_LOCAL  = 2'd0,
        CMD_TO_GLOBAL = 2'd1,
        CMD_VERTICAL  = 2'd2
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_SIN_LAT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COS_LAT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SIN_LON = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_COS_LON = CFG_IDX_W'(3);

    localparam trig_t TRIG_ZERO = '0;
    localparam trig_t TRIG_ONE  = TRIG_W'(1) << TRIG_FRACTION_BITS;

    localparam prod_t PAIR_HALF = (2 * TRIG_W)'(1) << (TRIG_FRACTION_BITS - 1);
    localparam comp_t SAT_MAX   = {1'b0, {(COMPONENT_WIDTH - 1){1'b1}}};
    localparam comp_t SAT_MIN   = {1'b1, {(COMPONENT_WIDTH - 1){1'b0}}};

    // Product of two trig values, rounded half up back to trig scale.
    function automatic ent_t trig_pair(input trig_t a, input trig_t b);
        prod_t p;
        p = prod_t'(a) * prod_t'(b) + PAIR_HALF;
        return ent_t'(p >>> TRIG_FRACTION_BITS);
    endfunction

endpackage

`default_nettype wire

// File: sv/topocentric_vector_rotation_top.sv
// A result is offered once its item has passed through every register stage.
// Throughput: one item per cycle while m_tready is high; six register stages
// (input, matrix select, split multiply, partial sums, total, saturate) each
// hold one item. s_tready stays high while any stage is empty, so bubbles
// close under stall. Reset (aresetn low, synchronous) empties the pipeline
// and loads sin = 0, cos = 1.0 into the trig registers.
`default_nettype none
`include "assert_macros.svh"

module topocentric_vector_rotation_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // tdata, low bits up: in_x, in_y, in_z
    input  wire logic [tvr_pkg::DATA_W-1:0]            s_tdata,
    // tuser: command
    input  wire logic [1:0]                            s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // tdata, low bits up: out_x, out_y, out_z
    output logic [tvr_pkg::DATA_W-1:0]                 m_tdata,
    // tuser: saturated
    output logic                                       m_tuser,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [tvr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [tvr_pkg::TRIG_W-1:0]            cfg_data
);

    localparam int N  = tvr_pkg::NUM_COMP;
    localparam int CW = tvr_pkg::COMPONENT_WIDTH;
    localparam int TF = tvr_pkg::TRIG_FRACTION_BITS;
    localparam int LW = tvr_pkg::LO_W;

    // Trig registers.
    tvr_pkg::trig_t sin_lat_reg, cos_lat_reg, sin_lon_reg, cos_lon_reg;

    // Rounded trig products; they follow the trig registers in the next cycle.
    tvr_pkg::ent_t p_sc_reg, p_ss_reg, p_cc_reg, p_cs_reg;

    // Pipeline control.
    logic [tvr_pkg::PIPE_DEPTH-1:0] vld_reg, vld_next, en;

    // Stage 1: accepted item.
    tvr_pkg::cmd_t  s1_cmd_reg, s1_cmd_next;
    tvr_pkg::comp_t s1_v_reg [N], s1_v_next [N];
    // Stage 2: selected matrix and rounding bias.
    tvr_pkg::comp_t s2_v_reg [N], s2_v_next [N];
    tvr_pkg::ent_t  s2_e_reg [N][N], s2_e_next [N][N];
    tvr_pkg::bias_t s2_b_reg [N], s2_b_next [N];
    // Stage 3: partial products.
    tvr_pkg::pl_t   s3_pl_reg [N][N], s3_pl_next [N][N];
    tvr_pkg::ph_t   s3_ph_reg [N][N], s3_ph_next [N][N];
    tvr_pkg::bias_t s3_b_reg [N], s3_b_next [N];
    // Stage 4: per-component partial sums.
    tvr_pkg::sl_t   s4_sl_reg [N], s4_sl_next [N];
    tvr_pkg::sh_t   s4_sh_reg [N], s4_sh_next [N];
    tvr_pkg::bias_t s4_b_reg [N], s4_b_next [N];
    // Stage 5: full sums including rounding bias.
    tvr_pkg::sum_t  s5_t_reg [N], s5_t_next [N];
    // Stage 6: saturated result.
    tvr_pkg::comp_t s6_o_reg [N], s6_o_next [N];
    logic           s6_sat_reg, s6_sat_next;

    // A stage may load when it is empty or its content moves on.
    always_comb begin
        en[tvr_pkg::PIPE_DEPTH-1] = !vld_reg[tvr_pkg::PIPE_DEPTH-1] || m_tready;
        for (int k = tvr_pkg::PIPE_DEPTH - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < tvr_pkg::PIPE_DEPTH; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_comb begin
        tvr_pkg::ent_t fwd [N][N];
        tvr_pkg::ent_t vsel [N];
        tvr_pkg::res_t r;
        logic [tvr_pkg::RES_W-CW:0] hi;

        // Stage 1.
        s1_cmd_next = tvr_pkg::cmd_t'(s_tuser);
        for (int j = 0; j < N; j++) begin
            s1_v_next[j] = s_tdata[j*CW +: CW];
        end

        // Stage 2: forward matrix rows east, north, up.
        fwd[0][0] = -tvr_pkg::ent_t'(sin_lon_reg);
        fwd[0][1] = tvr_pkg::ent_t'(cos_lon_reg);
        fwd[0][2] = '0;
        fwd[1][0] = -p_sc_reg;
        fwd[1][1] = -p_ss_reg;
        fwd[1][2] = tvr_pkg::ent_t'(cos_lat_reg);
        fwd[2][0] = p_cc_reg;
        fwd[2][1] = p_cs_reg;
        fwd[2][2] = tvr_pkg::ent_t'(sin_lat_reg);
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                case (s1_cmd_reg)
                    tvr_pkg::CMD_TO_LOCAL:  s2_e_next[i][j] = fwd[i][j];
                    tvr_pkg::CMD_TO_GLOBAL: s2_e_next[i][j] = fwd[j][i];
                    default:                s2_e_next[i][j] = '0;
                endcase
            end
            s2_v_next[i] = s1_v_reg[i];
        end
        // The vertical vector rides in the bias, pre-scaled so the final
        // rounding shift returns it unchanged; the products are all zero then.
        if (s1_cmd_reg == tvr_pkg::CMD_VERTICAL) begin
            vsel[0] = p_cc_reg;
            vsel[1] = p_cs_reg;
            vsel[2] = tvr_pkg::ent_t'(sin_lat_reg);
        end else begin
            vsel[0] = '0;
            vsel[1] = '0;
            vsel[2] = '0;
        end
        for (int i = 0; i < N; i++) begin
            s2_b_next[i] = {vsel[i], 1'b1, (TF - 1)'(0)};
        end

        // Stage 3: each component times each entry, in two halves.
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                s3_pl_next[i][j] = tvr_pkg::pl_t'($signed({1'b0, s2_v_reg[j][LW-1:0]}))
                                 * tvr_pkg::pl_t'(s2_e_reg[i][j]);
                s3_ph_next[i][j] = tvr_pkg::ph_t'($signed(s2_v_reg[j][CW-1:LW]))
                                 * tvr_pkg::ph_t'(s2_e_reg[i][j]);
            end
            s3_b_next[i] = s2_b_reg[i];
        end

        // Stage 4.
        for (int i = 0; i < N; i++) begin
            s4_sl_next[i] = tvr_pkg::sl_t'(s3_pl_reg[i][0]) + tvr_pkg::sl_t'(s3_pl_reg[i][1])
                          + tvr_pkg::sl_t'(s3_pl_reg[i][2]);
            s4_sh_next[i] = tvr_pkg::sh_t'(s3_ph_reg[i][0]) + tvr_pkg::sh_t'(s3_ph_reg[i][1])
                          + tvr_pkg::sh_t'(s3_ph_reg[i][2]);
            s4_b_next[i]  = s3_b_reg[i];
        end

        // Stage 5.
        for (int i = 0; i < N; i++) begin
            s5_t_next[i] = (tvr_pkg::sum_t'(s4_sh_reg[i]) <<< LW)
                         + tvr_pkg::sum_t'(s4_sl_reg[i])
                         + tvr_pkg::sum_t'(s4_b_reg[i]);
        end

        // Stage 6: drop the fraction and clip to the component range.
        s6_sat_next = 1'b0;
        for (int i = 0; i < N; i++) begin
            r  = tvr_pkg::res_t'(s5_t_reg[i] >>> TF);
            hi = r[tvr_pkg::RES_W-1:CW-1];
            if (hi == '0 || hi == '1) begin
                s6_o_next[i] = r[CW-1:0];
            end else begin
                s6_o_next[i] = r[tvr_pkg::RES_W-1] ? tvr_pkg::SAT_MIN : tvr_pkg::SAT_MAX;
                s6_sat_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            sin_lat_reg <= tvr_pkg::TRIG_ZERO;
            cos_lat_reg <= tvr_pkg::TRIG_ONE;
            sin_lon_reg <= tvr_pkg::TRIG_ZERO;
            cos_lon_reg <= tvr_pkg::TRIG_ONE;
        end else begin
            vld_reg <= vld_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tvr_pkg::REG_SIN_LAT: sin_lat_reg <= cfg_data;
                    tvr_pkg::REG_COS_LAT: cos_lat_reg <= cfg_data;
                    tvr_pkg::REG_SIN_LON: sin_lon_reg <= cfg_data;
                    tvr_pkg::REG_COS_LON: cos_lon_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Products run free; user changes them only while pipeline idle; unchecked.
    always_ff @(posedge aclk) begin
        p_sc_reg <= tvr_pkg::trig_pair(sin_lat_reg, cos_lon_reg);
        p_ss_reg <= tvr_pkg::trig_pair(sin_lat_reg, sin_lon_reg);
        p_cc_reg <= tvr_pkg::trig_pair(cos_lat_reg, cos_lon_reg);
        p_cs_reg <= tvr_pkg::trig_pair(cos_lat_reg, sin_lon_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_cmd_reg <= s1_cmd_next;
            s1_v_reg   <= s1_v_next;
        end
        if (en[1]) begin
            s2_v_reg <= s2_v_next;
            s2_e_reg <= s2_e_next;
            s2_b_reg <= s2_b_next;
        end
        if (en[2]) begin
            s3_pl_reg <= s3_pl_next;
            s3_ph_reg <= s3_ph_next;
            s3_b_reg  <= s3_b_next;
        end
        if (en[3]) begin
            s4_sl_reg <= s4_sl_next;
            s4_sh_reg <= s4_sh_next;
            s4_b_reg  <= s4_b_next;
        end
        if (en[4]) begin
            s5_t_reg <= s5_t_next;
        end
        if (en[5]) begin
            s6_o_reg   <= s6_o_next;
            s6_sat_reg <= s6_sat_next;
        end
    end

    assign s_tready  = en[0];
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[tvr_pkg::PIPE_DEPTH-1];
    assign m_tuser   = s6_sat_reg;
    assign m_tdata   = tvr_pkg::DATA_W'({s6_o_reg[2], s6_o_reg[1], s6_o_reg[0]});

    // Any empty stage or a taken result must let a new item in.
    `ASSERT_PROP(a_ready_on_bubble, aclk, aresetn,
        (vld_reg != '1 || m_tready) |-> s_tready)
    // A stage that cannot move keeps its item; checked on stage 5.
    `ASSERT_PROP(a_stall_keeps_item, aclk, aresetn,
        (vld_reg[4] && !en[4]) |=> vld_reg[4])
    // A clipped result shows a limit value in some component.
    `ASSERT_PROP(a_sat_at_limit, aclk, aresetn,
        (m_tvalid && m_tuser) |->
            (s6_o_reg[0] == tvr_pkg::SAT_MAX || s6_o_reg[0] == tvr_pkg::SAT_MIN ||
             s6_o_reg[1] == tvr_pkg::SAT_MAX || s6_o_reg[1] == tvr_pkg::SAT_MIN ||
             s6_o_reg[2] == tvr_pkg::SAT_MAX || s6_o_reg[2] == tvr_pkg::SAT_MIN))
    // A register write lands in the addressed register; checked for cos_lon.
    `ASSERT_PROP(a_cfg_write, aclk, aresetn,
        (cfg_valid && cfg_ready && cfg_index == tvr_pkg::REG_COS_LON) |=>
            (cos_lon_reg == $past(cfg_data)))
    // An accepted item occupies the first stage next cycle.
    `ASSERT_NEVER(a_accept_lost, aclk, aresetn,
        $past(s_tvalid && s_tready) && !vld_reg[0])

endmodule

`default_nettype wire
